@@ rtl/core/lps_pkg.sv @@
package lps_pkg;

	// Default sizes handed to the top level.
	localparam int NUM_LEDS_DEF = 8;
	localparam int PROG_LEN_DEF = 16;

	// Request codes carried in req_type.
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;

	// Instruction kinds. Any other kind behaves as halt.
	localparam logic [1:0] KIND_CHANGE = 2'd1;
	localparam logic [1:0] KIND_JUMP   = 2'd2;

	// Level codes. The unused code is reported as toggle.
	localparam logic [1:0] LVL_TOGGLE     = 2'd2;
	localparam logic [1:0] LVL_TOGGLE_ALT = 2'd3;

	// One input word.
	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] led_index;
		logic [3:0] slot;
		logic [1:0] op_kind;
		logic [1:0] new_level;
		logic [7:0] wait_ticks;
		logic [3:0] jump_target;
		logic [7:0] repeat_count;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [2:0] out_led;
		logic [1:0] out_level;
		logic       last;
	} result_t;

	// One program slot as held in the program memory.
	typedef struct packed {
		logic [1:0] op_kind;
		logic [1:0] new_level;
		logic [7:0] wait_ticks;
		logic [3:0] jump_target;
		logic [7:0] repeat_count;
		logic [7:0] remaining;
	} instr_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic tick_init;
		logic led_begin;
		logic hold_dec;
		logic fetch;
		logic exec;
		logic next_led;
		logic flush;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hold_nz;
		logic pc_past;
		logic chain;
		logic last_led;
	} stat_t;

endpackage

@@ rtl/core/led_pattern_program_sequencer_top.sv @@
// Channel  | Ports                  | Handshake
// ---------+------------------------+------------------------------------------
// input    | item (lps_pkg::item_t) | taken when start is high and busy is low
// result   | result (result_t)      | valid for one cycle while done is high
//
// Load and start words never raise busy.
// A tick walks all LEDs and ends in a flush state. A holding LED only has its
// hold counter decremented; otherwise each program slot that is run goes
// through a fetch state and an execute state on the program memory's single
// read port. Jump chains go back to the fetch state for each jump, at most
// PROG_LEN per LED. The reset is asynchronous and needs no clearing pass.
// Each change is held until the next change or the end of its tick, so that
// the final word can carry last; the receiver cannot stall.
module led_pattern_program_sequencer_top #(
	parameter int NUM_LEDS = lps_pkg::NUM_LEDS_DEF,
	parameter int PROG_LEN = lps_pkg::PROG_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  lps_pkg::item_t   item,
	output logic             done,
	output lps_pkg::result_t result
);
	import lps_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencing of ticks across LEDs and jump chains.
	lps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (item.req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	// Program memory, per-LED counters and result register.
	lps_datapath #(
		.NUM_LEDS (NUM_LEDS),
		.PROG_LEN (PROG_LEN)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

endmodule

@@ rtl/core/lps_ctrl.sv @@
module lps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    req_type,
	input  lps_pkg::stat_t stat,
	output lps_pkg::cmd_t  cmd,
	output logic          busy
);
	import lps_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LED   = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_EXEC  = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       advance;

	assign busy = (state_q != ST_IDLE);

	// Next-state logic and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		advance = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = start;
				if (start && req_type == REQ_TICK) begin
					cmd.tick_init = 1'b1;
					state_d = ST_LED;
				end
			end
			ST_LED: begin
				cmd.led_begin = 1'b1;
				if (stat.hold_nz) begin
					cmd.hold_dec = 1'b1;
					advance = 1'b1;
				end else begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (stat.pc_past) begin
					advance = 1'b1;
				end else begin
					cmd.fetch = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.chain) begin
					state_d = ST_FETCH;
				end else begin
					advance = 1'b1;
				end
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// Move to the next LED, or finish the tick after the last one.
		if (advance) begin
			if (stat.last_led) begin
				state_d = ST_FLUSH;
			end else begin
				cmd.next_led = 1'b1;
				state_d = ST_LED;
			end
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_flush_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |=> state_q == ST_IDLE)
		else $error("tick did not end after flush");
	a_exec_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |-> $past(state_q) == ST_FETCH)
		else $error("execute without a fetch");
	a_short_items: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type != REQ_TICK) |=> !busy)
		else $error("load or start made the block busy");
`endif

endmodule

@@ rtl/core/lps_datapath.sv @@
module lps_datapath #(
	parameter int NUM_LEDS = 8,
	parameter int PROG_LEN = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lps_pkg::cmd_t    cmd,
	input  lps_pkg::item_t   item,
	output lps_pkg::stat_t   stat,
	output logic             done,
	output lps_pkg::result_t result
);
	import lps_pkg::*;

	localparam int LED_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int SLOT_W = $clog2(PROG_LEN);
	localparam int PC_R   = $clog2(PROG_LEN + 1);
	localparam int PC_W   = (PC_R > 4) ? PC_R : 4;
	localparam int JC_W   = $clog2(PROG_LEN + 1);
	localparam int ADDR_W = LED_W + SLOT_W;
	localparam int DEPTH  = 1 << ADDR_W;

	logic [LED_W-1:0]    led_q;
	logic [JC_W-1:0]     jcnt_q;
	logic [PC_W-1:0]     pc_q [NUM_LEDS];
	logic [7:0]          hold_q [NUM_LEDS];
	logic [NUM_LEDS-1:0] v0_q;
	instr_t              mem_q [DEPTH];
	instr_t              rd_q;
	logic                inv_q;
	logic                pend_v_q;
	logic [2:0]          pend_led_q;
	logic [1:0]          pend_lvl_q;
	logic                done_q;
	result_t             result_q;

	logic [LED_W-1:0]  in_led;
	logic [SLOT_W-1:0] in_slot;
	logic              led_ok;
	logic              slot_ok;
	logic              do_load;
	logic              do_start;
	logic [PC_W-1:0]   cur_pc;
	logic [PC_W-1:0]   pc_inc;
	logic [SLOT_W-1:0] cur_slot;
	logic [7:0]        cur_hold;
	logic              is_change;
	logic              is_jump;
	logic              jump_ok;
	logic              jump_go;
	logic              jump_do;
	logic [1:0]        lvl;
	instr_t            load_word;
	instr_t            wb_word;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	instr_t            mem_wd;

	// Address checks for load and start words.
	assign in_led   = LED_W'(item.led_index);
	assign in_slot  = SLOT_W'(item.slot);
	assign led_ok   = int'(item.led_index) < NUM_LEDS;
	assign slot_ok  = int'(item.slot) < PROG_LEN;
	assign do_load  = cmd.accept && item.req_type == REQ_LOAD && led_ok && slot_ok;
	assign do_start = cmd.accept && item.req_type == REQ_START && led_ok;

	// Per-LED state of the LED being stepped.
	assign cur_pc   = pc_q[led_q];
	assign pc_inc   = cur_pc + PC_W'(1);
	assign cur_slot = cur_pc[SLOT_W-1:0];
	assign cur_hold = hold_q[led_q];

	// Decode of the fetched instruction; an unloaded slot zero is halt.
	assign is_change = !inv_q && rd_q.op_kind == KIND_CHANGE;
	assign is_jump   = !inv_q && rd_q.op_kind == KIND_JUMP;
	assign jump_ok   = jcnt_q != JC_W'(PROG_LEN);
	assign jump_go   = rd_q.repeat_count == 8'd0 || rd_q.remaining != 8'd0;
	assign jump_do   = cmd.exec && is_jump && jump_ok;
	assign lvl       = (rd_q.new_level == LVL_TOGGLE_ALT) ? LVL_TOGGLE : rd_q.new_level;

	// Words written into the program memory.
	always_comb begin
		load_word.op_kind      = item.op_kind;
		load_word.new_level    = item.new_level;
		load_word.wait_ticks   = item.wait_ticks;
		load_word.jump_target  = item.jump_target;
		load_word.repeat_count = item.repeat_count;
		load_word.remaining    = item.repeat_count;
		wb_word = rd_q;
		if (!jump_go) begin
			wb_word.remaining = rd_q.repeat_count;
		end else if (rd_q.remaining != 8'd0) begin
			wb_word.remaining = rd_q.remaining - 8'd1;
		end
	end

	assign mem_we = do_load || jump_do;
	assign mem_wa = do_load ? {in_led, in_slot} : {led_q, cur_slot};
	assign mem_wd = do_load ? load_word : wb_word;

	// Program memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (cmd.fetch) begin
			rd_q  <= mem_q[{led_q, cur_slot}];
			inv_q <= (cur_pc == '0) && !v0_q[led_q];
		end
	end

	// Program counters, hold counters and slot-zero valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				pc_q[i]   <= '0;
				hold_q[i] <= '0;
			end
			v0_q <= '0;
		end else begin
			if (do_load && in_slot == '0) begin
				v0_q[in_led] <= 1'b1;
			end
			if (do_start) begin
				pc_q[in_led]   <= '0;
				hold_q[in_led] <= '0;
			end
			if (cmd.hold_dec) begin
				hold_q[led_q] <= cur_hold - 8'd1;
			end
			if (cmd.exec && is_change) begin
				pc_q[led_q]   <= pc_inc;
				hold_q[led_q] <= rd_q.wait_ticks;
			end
			if (jump_do) begin
				pc_q[led_q] <= jump_go ? PC_W'(rd_q.jump_target) : pc_inc;
			end
		end
	end

	// LED walk and jump chain counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q  <= '0;
			jcnt_q <= '0;
		end else begin
			if (cmd.tick_init) begin
				led_q <= '0;
			end else if (cmd.next_led) begin
				led_q <= led_q + LED_W'(1);
			end
			if (cmd.led_begin) begin
				jcnt_q <= '0;
			end else if (jump_do) begin
				jcnt_q <= jcnt_q + JC_W'(1);
			end
		end
	end

	// One change is held back so the final word of a tick can carry last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.exec && is_change) begin
				done_q   <= pend_v_q;
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				done_q   <= pend_v_q;
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && is_change) begin
			result_q   <= '{out_led: pend_led_q, out_level: pend_lvl_q, last: 1'b0};
			pend_led_q <= 3'(led_q);
			pend_lvl_q <= lvl;
		end else if (cmd.flush) begin
			result_q <= '{out_led: pend_led_q, out_level: pend_lvl_q, last: 1'b1};
		end
	end

	assign done   = done_q;
	assign result = result_q;

	assign stat.hold_nz  = cur_hold != 8'd0;
	assign stat.pc_past  = int'(cur_pc) >= PROG_LEN;
	assign stat.chain    = is_jump && jump_ok;
	assign stat.last_led = led_q == LED_W'(NUM_LEDS - 1);

`ifndef SYNTHESIS
	a_jump_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(jcnt_q) <= PROG_LEN)
		else $error("jump chain counter ran past its bound");
	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.last) |=> !done_q)
		else $error("result word after the final word of a tick");
	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_init |-> !pend_v_q)
		else $error("held change left over from an earlier tick");
`endif

endmodule
